@@ hw/rtl/tbrl_pkg.sv @@
package tbrl_pkg;

    // One second in nanoseconds
    localparam logic [31:0] NS_PER_SEC = 32'd1000000000;

    // Regeneration sums are held saturated at 2^33, which is above any capacity
    localparam logic [33:0] GAIN_SAT = 34'h2_0000_0000;

    typedef enum logic [1:0] {
        OP_RESET = 2'd0,
        OP_QUERY = 2'd1,
        OP_TAKE  = 2'd2,
        OP_WAIT  = 2'd3
    } opcode_t;

    // Configuration register indexes
    localparam logic [1:0] REG_RATE = 2'd0;
    localparam logic [1:0] REG_MAX  = 2'd1;
    localparam logic [1:0] REG_INIT = 2'd2;

    typedef struct packed {
        logic [31:0] rate;
        logic [31:0] max_tokens;
        logic [31:0] init_tokens;
    } cfg_t;

    typedef struct packed {
        opcode_t     opcode;
        logic [63:0] now_nanos;
        logic [31:0] request_count;
    } request_t;

    typedef struct packed {
        logic        granted;
        logic        status;
        logic [63:0] wait_nanos;
        logic [31:0] tokens_now;
    } result_t;

    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [31:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [63:0] quot;
        logic [31:0] rem;
    } div_rsp_t;

    // Add two saturated sums and saturate again
    function automatic logic [33:0] sat_add(input logic [33:0] a, input logic [33:0] b);
        logic [34:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s > {1'b0, GAIN_SAT}) ? GAIN_SAT : s[33:0];
    endfunction

endpackage

@@ hw/rtl/tbrl_div.sv @@
module tbrl_div
    import tbrl_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic        busy_reg;
    logic        done_reg;
    logic [5:0]  cnt_reg;
    logic [63:0] num_reg;
    logic [31:0] rem_reg;
    logic [31:0] den_reg;

    logic [32:0] trial;
    logic        qbit;
    logic [32:0] diff;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    assign trial = {rem_reg, num_reg[63]};
    assign qbit  = (trial >= {1'b0, den_reg});
    assign diff  = trial - {1'b0, den_reg};

    // Control: run 64 steps per request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 6'd1;
            if (cnt_reg == 6'd63)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Datapath: quotient bits shift into the dividend register
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            num_reg <= req.dividend;
            rem_reg <= '0;
            den_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[62:0], qbit};
            rem_reg <= qbit ? diff[31:0] : trial[31:0];
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quot = num_reg;
    assign rsp.rem  = rem_reg;

    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !busy_reg)
        else $error("divider started while busy");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("divider done while busy");

endmodule

@@ hw/rtl/tbrl_seq.sv @@
module tbrl_seq
    import tbrl_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  request_t req_in,
    input  cfg_t     cfg,
    output logic     res_valid,
    input  logic     res_ready,
    output result_t  res,
    output div_req_t div_req,
    input  div_rsp_t div_rsp
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SEC_START,
        S_SEC_DIV,
        S_GAIN,
        S_FRAC_START,
        S_FRAC_DIV,
        S_APPLY,
        S_EVAL,
        S_W1_START,
        S_W1_DIV,
        S_W2_START,
        S_W2_DIV,
        S_W2_MUL,
        S_W2R_START,
        S_W2R_DIV,
        S_DONE
    } state_t;

    state_t      state_reg;
    opcode_t     op_reg;
    logic [63:0] now_reg;
    logic [31:0] req_reg;
    logic [63:0] prod_reg;
    logic [33:0] gain_reg;
    logic [30:0] fn_reg;
    logic        wrap_reg;
    logic        secs_big_reg;
    logic [31:0] r_reg;
    logic [63:0] wait_reg;
    logic        granted_reg;
    logic        status_reg;
    logic [31:0] token_count_reg;
    logic [30:0] frac_nanos_reg;
    logic [31:0] frac_tokens_reg;
    logic [63:0] last_time_reg;

    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] prod;
    logic [33:0] prod_sat;
    logic [31:0] fn_sum;
    logic        fn_wrap;
    logic [31:0] fn_adj;
    logic [31:0] rate_left;
    logic [31:0] nt;
    logic [31:0] nt_gain;
    logic [33:0] tot;
    logic        enough;
    logic [31:0] deficit;
    logic [31:0] target;
    logic [63:0] ceil_q;
    logic [31:0] init_clip;

    // Shared multiplier, operands picked by state
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_SEC_DIV:
            begin
                mul_a = div_rsp.quot[31:0];
                mul_b = cfg.rate;
            end
            S_GAIN:
            begin
                mul_a = {1'b0, fn_reg};
                mul_b = cfg.rate;
            end
            S_EVAL:
            begin
                mul_a = target;
                mul_b = NS_PER_SEC;
            end
            S_W2_DIV:
            begin
                mul_a = div_rsp.quot[31:0];
                mul_b = NS_PER_SEC;
            end
            S_W2_MUL:
            begin
                mul_a = r_reg;
                mul_b = NS_PER_SEC;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = {32'b0, mul_a} * {32'b0, mul_b};

    // Regeneration arithmetic
    assign prod_sat  = (|prod_reg[63:33]) ? GAIN_SAT : {1'b0, prod_reg[32:0]};
    assign fn_sum    = {1'b0, frac_nanos_reg} + {1'b0, div_rsp.rem[30:0]};
    assign fn_wrap   = (fn_sum >= NS_PER_SEC);
    assign fn_adj    = fn_wrap ? (fn_sum - NS_PER_SEC) : fn_sum;
    assign rate_left = (cfg.rate > frac_tokens_reg) ? (cfg.rate - frac_tokens_reg) : '0;
    assign nt        = div_rsp.quot[31:0];
    assign nt_gain   = wrap_reg ? nt
                     : ((nt > frac_tokens_reg) ? (nt - frac_tokens_reg) : '0);
    assign tot       = sat_add(gain_reg, {2'b0, token_count_reg});

    // Request evaluation
    assign enough    = (token_count_reg >= req_reg);
    assign deficit   = req_reg - token_count_reg;
    assign target    = deficit + frac_tokens_reg;
    assign ceil_q    = div_rsp.quot + {63'b0, (div_rsp.rem != '0)};
    assign init_clip = (cfg.init_tokens < cfg.max_tokens) ? cfg.init_tokens : cfg.max_tokens;

    // Divider requests
    assign div_req.start    = (state_reg inside {S_SEC_START, S_FRAC_START,
                                                 S_W1_START, S_W2_START, S_W2R_START});
    assign div_req.dividend = prod_reg;
    assign div_req.divisor  = (state_reg inside {S_SEC_START, S_FRAC_START})
                            ? NS_PER_SEC : cfg.rate;

    // Sequencer and bucket state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            op_reg          <= OP_RESET;
            now_reg         <= '0;
            req_reg         <= '0;
            prod_reg        <= '0;
            gain_reg        <= '0;
            fn_reg          <= '0;
            wrap_reg        <= 1'b0;
            secs_big_reg    <= 1'b0;
            r_reg           <= '0;
            wait_reg        <= '0;
            granted_reg     <= 1'b0;
            status_reg      <= 1'b0;
            token_count_reg <= '0;
            frac_nanos_reg  <= '0;
            frac_tokens_reg <= '0;
            last_time_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        op_reg      <= req_in.opcode;
                        now_reg     <= req_in.now_nanos;
                        req_reg     <= req_in.request_count;
                        granted_reg <= 1'b0;
                        status_reg  <= 1'b0;
                        wait_reg    <= '0;
                        if (req_in.opcode == OP_RESET)
                        begin
                            token_count_reg <= init_clip;
                            frac_nanos_reg  <= '0;
                            frac_tokens_reg <= '0;
                            last_time_reg   <= req_in.now_nanos;
                            state_reg       <= S_DONE;
                        end
                        else if (req_in.now_nanos > last_time_reg)
                        begin
                            prod_reg  <= req_in.now_nanos - last_time_reg;
                            state_reg <= S_SEC_START;
                        end
                        else
                        begin
                            state_reg <= S_EVAL;
                        end
                    end
                end
                S_SEC_START:
                begin
                    state_reg <= S_SEC_DIV;
                end
                S_SEC_DIV:
                begin
                    // split elapsed time into seconds and leftover nanoseconds
                    if (div_rsp.done)
                    begin
                        prod_reg     <= prod;
                        secs_big_reg <= |div_rsp.quot[63:32];
                        fn_reg       <= fn_adj[30:0];
                        wrap_reg     <= fn_wrap;
                        state_reg    <= S_GAIN;
                    end
                end
                S_GAIN:
                begin
                    if (secs_big_reg && (cfg.rate != '0))
                    begin
                        gain_reg <= wrap_reg ? sat_add(GAIN_SAT, {2'b0, rate_left}) : GAIN_SAT;
                    end
                    else
                    begin
                        gain_reg <= wrap_reg ? sat_add(prod_sat, {2'b0, rate_left}) : prod_sat;
                    end
                    prod_reg  <= prod;
                    state_reg <= S_FRAC_START;
                end
                S_FRAC_START:
                begin
                    state_reg <= S_FRAC_DIV;
                end
                S_FRAC_DIV:
                begin
                    // fold in the fractional tokens of the sub-second part
                    if (div_rsp.done)
                    begin
                        gain_reg        <= sat_add(gain_reg, {2'b0, nt_gain});
                        frac_tokens_reg <= nt;
                        frac_nanos_reg  <= fn_reg;
                        state_reg       <= S_APPLY;
                    end
                end
                S_APPLY:
                begin
                    token_count_reg <= (tot > {2'b0, cfg.max_tokens}) ? cfg.max_tokens : tot[31:0];
                    last_time_reg   <= now_reg;
                    state_reg       <= S_EVAL;
                end
                S_EVAL:
                begin
                    granted_reg <= enough;
                    state_reg   <= S_DONE;
                    case (op_reg)
                        OP_TAKE:
                        begin
                            if (enough)
                            begin
                                token_count_reg <= token_count_reg - req_reg;
                            end
                            else
                            begin
                                status_reg <= 1'b1;
                            end
                        end
                        OP_WAIT:
                        begin
                            if (!enough)
                            begin
                                if (cfg.rate == '0)
                                begin
                                    wait_reg <= '1;
                                end
                                else if (deficit < rate_left)
                                begin
                                    prod_reg  <= prod;
                                    state_reg <= S_W1_START;
                                end
                                else
                                begin
                                    wait_reg  <= {32'b0, NS_PER_SEC - {1'b0, frac_nanos_reg}};
                                    prod_reg  <= {32'b0, deficit - rate_left};
                                    state_reg <= S_W2_START;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                S_W1_START:
                begin
                    state_reg <= S_W1_DIV;
                end
                S_W1_DIV:
                begin
                    // wait within the current second
                    if (div_rsp.done)
                    begin
                        wait_reg  <= (ceil_q > {33'b0, frac_nanos_reg})
                                   ? (ceil_q - {33'b0, frac_nanos_reg}) : '0;
                        state_reg <= S_DONE;
                    end
                end
                S_W2_START:
                begin
                    state_reg <= S_W2_DIV;
                end
                S_W2_DIV:
                begin
                    // whole seconds of deficit beyond the current second
                    if (div_rsp.done)
                    begin
                        prod_reg  <= prod;
                        r_reg     <= div_rsp.rem;
                        state_reg <= S_W2_MUL;
                    end
                end
                S_W2_MUL:
                begin
                    wait_reg  <= wait_reg + prod_reg;
                    prod_reg  <= prod;
                    state_reg <= S_W2R_START;
                end
                S_W2R_START:
                begin
                    state_reg <= S_W2R_DIV;
                end
                S_W2R_DIV:
                begin
                    if (div_rsp.done)
                    begin
                        wait_reg  <= wait_reg + ceil_q;
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (res_ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_ready       = (state_reg == S_IDLE);
    assign res_valid      = (state_reg == S_DONE);
    assign res.granted    = granted_reg;
    assign res.status     = status_reg;
    assign res.wait_nanos = wait_reg;
    assign res.tokens_now = token_count_reg;

    a_frac_below_sec: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, frac_nanos_reg} < NS_PER_SEC)
        else $error("fractional nanoseconds reached one second");

    a_regen_capped: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_APPLY) |=> (token_count_reg <= cfg.max_tokens))
        else $error("regenerated count above capacity");

    a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider request while busy");

endmodule

@@ hw/rtl/token_bucket_rate_limiter.sv @@
// Channel  Direction  Signals                      Contents
// s        in         s_tvalid s_tready s_tdata    request: opcode, time, count
//                     s_tuser
// m        out        m_tvalid m_tready m_tdata    result: granted, status, wait, tokens
// cfg      in         cfg_valid cfg_ready          register index and write data
//                     cfg_index cfg_data
//
// One request at a time. A reset request goes straight to the result, and a request with no
// elapsed time skips regeneration; regeneration adds two 64-step divisions by one billion and
// compute wait adds one division by the rate or two. The shared iterative divider sets the
// time each request takes. rst_n clears the bucket and loads the register defaults.
// A stalled result sits in the output register; the sequencer holds its next result until
// that frees.
module token_bucket_rate_limiter
    import tbrl_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [95:0]  s_tdata,    // now_nanos[63:0], request_count[95:64]
    input  logic [1:0]   s_tuser,    // opcode[1:0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata,    // granted[0], status[1], wait_nanos[65:2],
                                     // tokens_now[97:66], zero fill above
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    cfg_t     cfg_reg;
    request_t req_in;
    result_t  res;
    result_t  out_reg;
    logic     out_valid_reg;
    logic     res_valid;
    logic     res_ready;
    logic     seq_ready;
    div_req_t div_req;
    div_rsp_t div_rsp;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rate        <= 32'd1;
            cfg_reg.max_tokens  <= 32'd1;
            cfg_reg.init_tokens <= 32'd0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_RATE: cfg_reg.rate        <= cfg_data;
                REG_MAX:  cfg_reg.max_tokens  <= cfg_data;
                REG_INIT: cfg_reg.init_tokens <= cfg_data;
                default:  cfg_reg.rate        <= cfg_reg.rate;
            endcase
        end
    end

    // Unpack request
    assign req_in.opcode        = opcode_t'(s_tuser);
    assign req_in.now_nanos     = s_tdata[63:0];
    assign req_in.request_count = s_tdata[95:64];
    assign s_tready             = seq_ready;

    tbrl_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (seq_ready),
        .req_in    (req_in),
        .cfg       (cfg_reg),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .div_req   (div_req),
        .div_rsp   (div_rsp)
    );

    tbrl_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Output register
    assign res_ready = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid && res_ready)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_reg.tokens_now, out_reg.wait_nanos,
                       out_reg.status, out_reg.granted};

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request taken while previous still in work");

endmodule
